// ----- rtl/lcdws_pkg.sv -----
`timescale 1ns / 1ps

package lcdws_pkg;

	// Width of the tick counter; loaded counts saturate at its maximum.
	localparam int CntW = 16;
	localparam int TickW = 16;
	localparam int NibbleW = 4;

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam logic [1:0] REG_FOUR_BIT = 2'd0;
	localparam logic [1:0] REG_PULSE    = 2'd1;
	localparam logic [1:0] REG_HOLD     = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HI_PULSE,
		PH_HI_HOLD,
		PH_LO_PULSE,
		PH_LO_HOLD,
		PH_BYTE_PULSE,
		PH_BYTE_HOLD
	} phase_t;

	typedef struct packed {
		logic              four_bit_mode;
		logic [TickW-1:0]  pulse_ticks;
		logic [TickW-1:0]  hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_lines;
		logic       register_select;
		logic       enable_line;
		logic       busy_res;
		logic       rejected;
	} res_t;

	// A zero count behaves as one, and a count beyond the counter saturates.
	function automatic logic [CntW-1:0] load_count(logic [TickW-1:0] v);
		logic [32:0] c;
		logic [32:0] cmax;
		cmax = 33'((64'd1 << CntW) - 64'd1);
		c = 33'(v);
		if (c == 33'd0) begin
			c = 33'd1;
		end
		if (c > cmax) begin
			c = cmax;
		end
		return c[CntW-1:0];
	endfunction

endpackage

// ----- rtl/lcdws_seq.sv -----
`timescale 1ns / 1ps

module lcdws_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               action,
	input  logic [7:0]         data_byte,
	input  logic               is_character,
	input  lcdws_pkg::cfg_t    cfg,
	output lcdws_pkg::res_t    res
);
	import lcdws_pkg::*;

	phase_t            phase_q, phase_d;
	logic [CntW-1:0]   ticks_q, ticks_d;
	logic [7:0]        byte_q, byte_d;
	logic              char_q, char_d;
	logic              rej;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			byte_q  <= '0;
			char_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			byte_q  <= byte_d;
			char_q  <= char_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		ticks_d = ticks_q;
		byte_d  = byte_q;
		char_d  = char_q;
		rej     = 1'b0;
		if (action == ACT_WRITE) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				byte_d  = data_byte;
				char_d  = is_character;
				phase_d = cfg.four_bit_mode ? PH_HI_PULSE : PH_BYTE_PULSE;
				ticks_d = load_count(cfg.pulse_ticks);
			end
		end else if (phase_q != PH_IDLE) begin
			if (ticks_q <= CntW'(1)) begin
				case (phase_q)
					PH_HI_PULSE: begin
						phase_d = PH_HI_HOLD;
						ticks_d = load_count(cfg.hold_ticks);
					end
					PH_HI_HOLD: begin
						phase_d = PH_LO_PULSE;
						ticks_d = load_count(cfg.pulse_ticks);
					end
					PH_LO_PULSE: begin
						phase_d = PH_LO_HOLD;
						ticks_d = load_count(cfg.hold_ticks);
					end
					PH_BYTE_PULSE: begin
						phase_d = PH_BYTE_HOLD;
						ticks_d = load_count(cfg.hold_ticks);
					end
					default: begin
						phase_d = PH_IDLE;
						ticks_d = '0;
					end
				endcase
			end else begin
				ticks_d = ticks_q - CntW'(1);
			end
		end

		// The word shows the line levels after this item has been applied.
		res = '0;
		res.rejected = rej;
		res.busy_res = (phase_d != PH_IDLE);
		if (phase_d != PH_IDLE) begin
			res.register_select = char_d;
			case (phase_d)
				PH_HI_PULSE, PH_HI_HOLD: begin
					res.data_lines = {{(8-NibbleW){1'b0}}, byte_d[7:NibbleW]};
				end
				PH_LO_PULSE, PH_LO_HOLD: begin
					res.data_lines = {{(8-NibbleW){1'b0}}, byte_d[NibbleW-1:0]};
				end
				default: begin
					res.data_lines = byte_d;
				end
			endcase
			res.enable_line = (phase_d == PH_HI_PULSE) || (phase_d == PH_LO_PULSE)
				|| (phase_d == PH_BYTE_PULSE);
		end
	end

endmodule

// ----- rtl/character_lcd_write_sequencer_top.sv -----
`timescale 1ns / 1ps
// Channel  Handshake           Payload
// in       in_valid/in_stall   action, data_byte, is_character
// out      out_valid/out_stall data_lines, register_select, enable_line, busy_res, rejected
// cfg      cfg_we              cfg_index, cfg_data
// Every accepted input word yields one result word, registered and shown in the next cycle.
// A new word is taken each cycle; the only limit is the single output register.
// in_stall is high only while that register holds a word that out_stall holds back.
// Reset (arst_n low) returns to idle with the register defaults loaded.

module character_lcd_write_sequencer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [7:0]                  data_byte,
	input  logic                        is_character,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  data_lines,
	output logic                        register_select,
	output logic                        enable_line,
	output logic                        busy_res,
	output logic                        rejected,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [lcdws_pkg::TickW-1:0] cfg_data
);
	import lcdws_pkg::*;

	cfg_t  cfg_q;
	res_t  res_comb;
	res_t  res_s1;
	logic  valid_s1;
	logic  accept;

	assign in_stall = valid_s1 && out_stall;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_bit_mode <= 1'b1;
			cfg_q.pulse_ticks   <= TickW'(2);
			cfg_q.hold_ticks    <= TickW'(20);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOUR_BIT: cfg_q.four_bit_mode <= cfg_data[0];
				REG_PULSE:    cfg_q.pulse_ticks   <= cfg_data;
				REG_HOLD:     cfg_q.hold_ticks    <= cfg_data;
				default:      ;
			endcase
		end
	end

	lcdws_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (accept),
		.action       (action),
		.data_byte    (data_byte),
		.is_character (is_character),
		.cfg          (cfg_q),
		.res          (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_comb;
		end
	end

	assign out_valid       = valid_s1;
	assign data_lines      = res_s1.data_lines;
	assign register_select = res_s1.register_select;
	assign enable_line     = res_s1.enable_line;
	assign busy_res        = res_s1.busy_res;
	assign rejected        = res_s1.rejected;

endmodule

// ----- rtl/lcdws_chk.sv -----
`timescale 1ns / 1ps

module lcdws_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] data_lines,
	input logic       register_select,
	input logic       enable_line,
	input logic       busy_res,
	input logic       rejected
);

	// A refused write can only happen while a sequence runs.
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res)
		else $error("rejected word without busy");

	// Idle words drive all lines low.
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> data_lines == 8'd0 && !register_select && !enable_line)
		else $error("lines active while idle");

	// An accepted input word shows up as a result word in the next cycle.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted word produced no result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_lines) && $stable(busy_res))
		else $error("stalled result changed");

endmodule

bind character_lcd_write_sequencer_top lcdws_chk u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.data_lines      (data_lines),
	.register_select (register_select),
	.enable_line     (enable_line),
	.busy_res        (busy_res),
	.rejected        (rejected)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import lcdws_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam res_t IDLE_LINES = '0;

	typedef struct {
		logic             is_reg;
		logic             act;
		logic [7:0]       data_v;
		logic             ch;
		logic             typed;
		res_t             res;
		logic [1:0]       idx;
		logic [TickW-1:0] val;
	} step_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             action = ACT_TICK;
	logic [7:0]       data_byte = 8'h00;
	logic             is_character = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       data_lines;
	logic             register_select;
	logic             enable_line;
	logic             busy_res;
	logic             rejected;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = REG_FOUR_BIT;
	logic [TickW-1:0] cfg_data = '0;

	// Set with each word so that the monitor knows whether the row carries its own result.
	logic row_typed = 1'b0;
	res_t row_result = '0;

	int snd_pct = 0;
	int rcv_pct = 0;
	int snd_mix[4] = '{0, 87, 0, 36};
	int rcv_mix[4] = '{0, 0, 87, 36};
	int err_count = 0;
	int quiet_cycles = 0;

	// Predictor state.
	phase_t          seq_phase = PH_IDLE;
	logic [CntW-1:0] seq_ticks = '0;
	logic [7:0]      seq_byte = '0;
	logic            seq_char = 1'b0;
	cfg_t            seq_cfg = '{1'b1, 16'd2, 16'd20};
	res_t            pending_levels[$];

	character_lcd_write_sequencer_top u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rcv_pct);
	end

	function automatic logic [CntW-1:0] ticks_for(input logic [TickW-1:0] v);
		longint unsigned c;
		c = (v == '0) ? 1 : v;
		if (c > (64'd1 << CntW) - 1) begin
			c = (64'd1 << CntW) - 1;
		end
		return c[CntW-1:0];
	endfunction

	function automatic res_t step_lines(input logic act, input logic [7:0] d, input logic ch);
		res_t r;
		r = '0;
		if (act == ACT_WRITE) begin
			if (seq_phase != PH_IDLE) begin
				r.rejected = 1'b1;
			end else begin
				seq_byte = d;
				seq_char = ch;
				seq_phase = seq_cfg.four_bit_mode ? PH_HI_PULSE : PH_BYTE_PULSE;
				seq_ticks = ticks_for(seq_cfg.pulse_ticks);
			end
		end else if (seq_phase != PH_IDLE) begin
			if (seq_ticks > 1) begin
				seq_ticks = seq_ticks - 1'b1;
			end else begin
				case (seq_phase)
					PH_HI_PULSE: begin
						seq_phase = PH_HI_HOLD;
						seq_ticks = ticks_for(seq_cfg.hold_ticks);
					end
					PH_HI_HOLD: begin
						seq_phase = PH_LO_PULSE;
						seq_ticks = ticks_for(seq_cfg.pulse_ticks);
					end
					PH_LO_PULSE: begin
						seq_phase = PH_LO_HOLD;
						seq_ticks = ticks_for(seq_cfg.hold_ticks);
					end
					PH_BYTE_PULSE: begin
						seq_phase = PH_BYTE_HOLD;
						seq_ticks = ticks_for(seq_cfg.hold_ticks);
					end
					default: begin
						seq_phase = PH_IDLE;
						seq_ticks = '0;
					end
				endcase
			end
		end
		if (seq_phase != PH_IDLE) begin
			r.busy_res = 1'b1;
			r.register_select = seq_char;
			r.enable_line = (seq_phase == PH_HI_PULSE) || (seq_phase == PH_LO_PULSE)
				|| (seq_phase == PH_BYTE_PULSE);
			case (seq_phase)
				PH_HI_PULSE, PH_HI_HOLD: r.data_lines = 8'(seq_byte[7:NibbleW]);
				PH_LO_PULSE, PH_LO_HOLD: r.data_lines = 8'(seq_byte[NibbleW-1:0]);
				default: r.data_lines = seq_byte;
			endcase
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		res_t e;
		if (!arst_n) begin
			seq_phase = PH_IDLE;
			seq_ticks = '0;
			seq_byte = '0;
			seq_char = 1'b0;
			seq_cfg = '{1'b1, 16'd2, 16'd20};
			pending_levels.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FOUR_BIT: seq_cfg.four_bit_mode = cfg_data[0];
					REG_PULSE: seq_cfg.pulse_ticks = cfg_data;
					REG_HOLD: seq_cfg.hold_ticks = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				e = step_lines(action, data_byte, is_character);
				pending_levels.push_back(row_typed ? row_result : e);
			end
			if (out_valid && !out_stall) begin
				if (pending_levels.size() == 0) begin
					$display("%0t: result word with no expectation, got %h", $time,
						{data_lines, register_select, enable_line, busy_res, rejected});
					err_count++;
				end else begin
					e = pending_levels.pop_front();
					check_field("data_lines", e.data_lines, data_lines);
					check_field("register_select", e.register_select, register_select);
					check_field("enable_line", e.enable_line, enable_line);
					check_field("busy_res", e.busy_res, busy_res);
					check_field("rejected", e.rejected, rejected);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles < WATCHDOG_LIMIT) begin
			quiet_cycles <= quiet_cycles + 1;
		end else begin
			$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("tb NOT OK");
			$finish;
		end
	end

	function automatic step_row_t word_row(input logic act, input logic [7:0] d, input logic ch,
			input logic typed, input res_t res);
		step_row_t r;
		r.is_reg = 1'b0;
		r.act = act;
		r.data_v = d;
		r.ch = ch;
		r.typed = typed;
		r.res = res;
		r.idx = REG_FOUR_BIT;
		r.val = '0;
		return r;
	endfunction

	function automatic step_row_t reg_row(input logic [1:0] idx, input logic [TickW-1:0] val);
		step_row_t r;
		r = word_row(ACT_TICK, 8'h00, 1'b0, 1'b0, IDLE_LINES);
		r.is_reg = 1'b1;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	task automatic send_word(input logic act, input logic [7:0] d, input logic ch,
			input logic typed, input res_t res);
		@(negedge clk);
		while ($urandom_range(99) < snd_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		data_byte <= d;
		is_character <= ch;
		row_typed <= typed;
		row_result <= res;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	// Registers change only once every expected word has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_levels.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [TickW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic mode, input logic [TickW-1:0] pulse,
			input logic [TickW-1:0] hold, input int n, input int write_pm, input int spct,
			input int rpct);
		drain();
		write_reg(REG_FOUR_BIT, {15'($urandom), mode});
		write_reg(REG_PULSE, pulse);
		write_reg(REG_HOLD, hold);
		snd_pct = spct;
		rcv_pct = rpct;
		repeat (n) begin
			send_word(($urandom_range(999) < write_pm) ? ACT_WRITE : ACT_TICK,
				8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, IDLE_LINES);
		end
	endtask

	initial begin
		step_row_t script[$];

		// Reset values apply first: four-bit mode with a two-tick pulse.
		script.push_back(word_row(ACT_TICK, 8'hFF, 1'b1, 1'b1, IDLE_LINES));
		script.push_back(word_row(ACT_WRITE, 8'hFF, 1'b1, 1'b1,
			res_t'{8'h0F, 1'b1, 1'b1, 1'b1, 1'b0}));
		script.push_back(word_row(ACT_WRITE, 8'h00, 1'b0, 1'b1,
			res_t'{8'h0F, 1'b1, 1'b1, 1'b1, 1'b1}));
		// Zero counts behave as one tick from the next load on.
		script.push_back(reg_row(REG_HOLD, 16'h0000));
		script.push_back(reg_row(REG_PULSE, 16'h0000));
		repeat (4) script.push_back(word_row(ACT_TICK, 8'h00, 1'b0, 1'b0, IDLE_LINES));
		script.push_back(word_row(ACT_TICK, 8'h00, 1'b0, 1'b1, IDLE_LINES));
		script.push_back(reg_row(REG_FOUR_BIT, 16'h0000));
		script.push_back(word_row(ACT_WRITE, 8'h5A, 1'b0, 1'b1,
			res_t'{8'h5A, 1'b0, 1'b1, 1'b1, 1'b0}));
		script.push_back(word_row(ACT_TICK, 8'h00, 1'b0, 1'b0, IDLE_LINES));
		script.push_back(word_row(ACT_WRITE, 8'h00, 1'b1, 1'b0, IDLE_LINES));
		script.push_back(word_row(ACT_TICK, 8'h00, 1'b0, 1'b0, IDLE_LINES));
		script.push_back(word_row(ACT_WRITE, 8'h81, 1'b1, 1'b0, IDLE_LINES));
		// A mode change in mid-sequence waits for the next request.
		script.push_back(reg_row(REG_FOUR_BIT, 16'h0001));
		repeat (2) script.push_back(word_row(ACT_TICK, 8'h00, 1'b0, 1'b0, IDLE_LINES));
		script.push_back(word_row(ACT_WRITE, 8'h00, 1'b1, 1'b1,
			res_t'{8'h00, 1'b1, 1'b1, 1'b1, 1'b0}));
		repeat (4) script.push_back(word_row(ACT_TICK, 8'h00, 1'b0, 1'b0, IDLE_LINES));

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_reg) begin
				drain();
				write_reg(script[i].idx, script[i].val);
			end else begin
				send_word(script[i].act, script[i].data_v, script[i].ch, script[i].typed,
					script[i].res);
			end
		end

		run_phase(1'b1, 16'd2, 16'd20, 200, 30, 0, 0);
		for (int k = 0; k < 8; k++) begin
			run_phase(k[0], 16'($urandom_range(4)), 16'($urandom_range(4)), 180, 200,
				snd_mix[k / 2], rcv_mix[k / 2]);
		end
		// The largest hold count keeps the sequence busy, so later requests are refused.
		run_phase(1'b1, 16'h0001, 16'hFFFF, 100, 100, 0, 0);

		drain();
		repeat (4) @(negedge clk);
		if (err_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
